// ===== design/rstc_pkg.sv =====
// ----------------------------------------------------------------------------
// rstc_pkg
// Shared types, codes and fixed-point constants of the soil tension converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rstc_pkg;

  localparam int CHANNELS_DEF = 16;

  // Quotient format: 23 integer bits checked for overflow, 16 fraction bits.
  localparam int FRAC_BITS = 16;
  localparam int QINT      = 23;
  localparam int QBITS     = 39;

  localparam logic signed [39:0] RD_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] RD_MIN = 40'sh80_0000_0000;

  // Tension constants scaled by 1e9, results carry 16 fraction bits.
  localparam logic signed [62:0] NUM_K   = 63'sd268238848000000;
  localparam logic signed [55:0] DEN_K   = 56'sd65536000000000;
  localparam logic        [21:0] RES_K   = 22'd3213000;
  localparam logic        [13:0] SLOPE_K = 14'd9733;
  localparam logic        [23:0] TEMP_K  = 24'd12050000;

  // ceil(2^30 / 9), exact for dividends below 2^27.
  localparam logic        [26:0] RECIP9     = 27'd119304648;
  localparam logic signed [24:0] TC_DEFAULT = 25'sd1310720;
  localparam logic signed [16:0] TF_OFFSET  = 17'sd8192;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_RES     = 2'd1;
  localparam logic [1:0] KIND_TENSION = 2'd2;
  localparam logic [1:0] KIND_BAD     = 2'd3;

  typedef enum logic [2:0] {
    STAT_OK   = 3'd0,
    STAT_DIVZ = 3'd1,
    STAT_TDIV = 3'd2,
    STAT_BAD  = 3'd3,
    STAT_SAT  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_BAD,
    CLS_DIVZ,
    CLS_RES,
    CLS_TEN,
    CLS_TDIV
  } cls_t;

endpackage

`default_nettype wire

// ===== design/rstc_div_cell.sv =====
// ----------------------------------------------------------------------------
// rstc_div_cell
// One restoring division step: brings in one dividend bit, yields one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rstc_div_cell
  import rstc_pkg::*;
#(
  parameter int DW = 25,
  parameter int XW = 34
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [DW-1:0]    in_r,
  input  wire logic [DW-1:0]    in_d,
  input  wire logic [QBITS-1:0] in_bits,
  input  wire logic [QBITS-1:0] in_q,
  input  wire logic [XW-1:0]    in_x,
  output logic                  out_valid,
  output logic [DW-1:0]         out_r,
  output logic [DW-1:0]         out_d,
  output logic [QBITS-1:0]      out_bits,
  output logic [QBITS-1:0]      out_q,
  output logic [XW-1:0]         out_x
);

  logic [DW:0] r2;
  logic [DW:0] rsub;
  logic        ge;

  always_comb begin
    r2   = {in_r, in_bits[QBITS-1]};
    ge   = r2 >= {1'b0, in_d};
    rsub = r2 - {1'b0, in_d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r    <= ge ? rsub[DW-1:0] : r2[DW-1:0];
      out_d    <= in_d;
      out_bits <= {in_bits[QBITS-2:0], 1'b0};
      out_q    <= {in_q[QBITS-2:0], ge};
      out_x    <= in_x;
    end
  end

endmodule

`default_nettype wire

// ===== design/rstc_divider.sv =====
// ----------------------------------------------------------------------------
// rstc_divider
// Pipelined signed divider: num * 2^16 / den, truncated, saturated to 40 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rstc_divider
  import rstc_pkg::*;
#(
  parameter int NUMW = 46,
  parameter int DENW = 25,
  parameter int SW   = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic signed [NUMW-1:0] num,
  input  wire logic signed [DENW-1:0] den,
  input  wire logic [SW-1:0]          side,
  output logic                        out_valid,
  output logic signed [39:0]          quo,
  output logic                        sat,
  output logic [SW-1:0]               out_side
);

  localparam int CW = (NUMW > DENW) ? NUMW : DENW;
  localparam int XW = SW + 2;

  logic [NUMW-1:0] n_mag;
  logic [NUMW-1:0] n_top;
  logic [DENW-1:0] d_mag;
  logic            neg_c;
  logic            ovf_c;

  always_comb begin
    n_mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    d_mag = den[DENW-1] ? DENW'(-den) : DENW'(den);
    neg_c = num[NUMW-1] ^ den[DENW-1];
    n_top = n_mag >> QINT;
    // The integer part of the quotient must stay below 2^23.
    ovf_c = CW'(n_top) >= CW'(d_mag);
  end

  logic             v_s    [QBITS+1];
  logic [DENW-1:0]  r_s    [QBITS+1];
  logic [DENW-1:0]  d_s    [QBITS+1];
  logic [QBITS-1:0] bits_s [QBITS+1];
  logic [QBITS-1:0] q_s    [QBITS+1];
  logic [XW-1:0]    x_s    [QBITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_s[0]    <= DENW'(n_top);
      d_s[0]    <= d_mag;
      bits_s[0] <= {n_mag[QINT-1:0], {FRAC_BITS{1'b0}}};
      q_s[0]    <= '0;
      x_s[0]    <= {neg_c, ovf_c, side};
    end
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    rstc_div_cell #(
      .DW(DENW),
      .XW(XW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v_s[i]),
      .in_r     (r_s[i]),
      .in_d     (d_s[i]),
      .in_bits  (bits_s[i]),
      .in_q     (q_s[i]),
      .in_x     (x_s[i]),
      .out_valid(v_s[i+1]),
      .out_r    (r_s[i+1]),
      .out_d    (d_s[i+1]),
      .out_bits (bits_s[i+1]),
      .out_q    (q_s[i+1]),
      .out_x    (x_s[i+1])
    );
  end

  logic               neg_l;
  logic               ovf_l;
  logic signed [39:0] qz;
  logic signed [39:0] res_c;

  always_comb begin
    neg_l = x_s[QBITS][XW-1];
    ovf_l = x_s[QBITS][XW-2];
    qz    = $signed({1'b0, q_s[QBITS]});
    if (ovf_l) begin
      res_c = neg_l ? RD_MIN : RD_MAX;
    end else begin
      res_c = neg_l ? -qz : qz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_s[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo      <= res_c;
      sat      <= ovf_l;
      out_side <= x_s[QBITS][SW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/resistive_soil_tension_converter.sv =====
// ----------------------------------------------------------------------------
// resistive_soil_tension_converter
// Ratiometric sensor resistance and soil tension from three converter counts.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with one channel reading each: rail
//   counts, reference resistor, sensor kind and soil temperature. Results
//   leave on out_valid/out_ready as channel_out, reading (signed, 16 fraction
//   bits, ohms or kPa) and status, in the order the requests came in.
//   From acceptance to out_valid a request passes two input stages, the
//   resistance divider (41 stages), two product stages, the tension divider
//   (41 stages) and the output register. Each divider is a row of 39 cells
//   that each produce one quotient bit, so one request is taken every cycle
//   while in_ready is high. When the receiver stalls, the output register
//   holds its result and the pipeline keeps moving as long as the stage in
//   front of the output is empty; once it holds a result too, in_ready drops
//   and the whole pipeline freezes until out_ready returns. Reset empties
//   every stage; there is no other state and no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module resistive_soil_tension_converter
  import rstc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         channel,
  input  wire logic [1:0]         sensor_kind,
  input  wire logic [19:0]        ref_ohms,
  input  wire logic [23:0]        rail_high,
  input  wire logic [23:0]        rail_low,
  input  wire logic [23:0]        node_level,
  input  wire logic signed [16:0] soil_temp_f,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              channel_out,
  output logic signed [39:0]      reading,
  output logic [2:0]              status
);

  localparam logic [4:0] CH_LIM = 5'(CHANNELS);

  logic en;
  logic out_load;
  logic d2_valid;

  assign out_load = !out_valid || out_ready;
  assign en       = out_load || !d2_valid;
  assign in_ready = en;

  // Stage A: current-path product, divisor, class and the temperature product.
  cls_t               cls_c;
  logic signed [16:0] tdiff;
  logic [15:0]        tmag;
  logic [26:0]        tx;
  logic signed [45:0] prod_c;
  logic signed [24:0] den_c;

  always_comb begin
    if ({1'b0, channel} >= CH_LIM) begin
      cls_c = CLS_BAD;
    end else begin
      case (sensor_kind)
        KIND_NONE:    cls_c = CLS_ZERO;
        KIND_RES:     cls_c = (rail_high == node_level) ? CLS_DIVZ : CLS_RES;
        KIND_TENSION: cls_c = (rail_high == node_level) ? CLS_DIVZ : CLS_TEN;
        default:      cls_c = CLS_BAD;
      endcase
    end
    prod_c = ($signed({1'b0, node_level}) - $signed({1'b0, rail_low}))
             * $signed({1'b0, ref_ohms});
    den_c  = $signed({1'b0, rail_high}) - $signed({1'b0, node_level});
    tdiff  = $signed({1'b0, soil_temp_f[15:0]}) - TF_OFFSET;
    tmag   = tdiff[16] ? 16'(-tdiff) : tdiff[15:0];
    tx     = {1'b0, tmag, 10'b0} + {3'b0, tmag, 8'b0};
  end

  logic               a_valid;
  logic signed [45:0] a_prod;
  logic signed [24:0] a_den;
  logic [3:0]         a_chan;
  cls_t               a_cls;
  logic               a_tdef;
  logic               a_tneg;
  logic [53:0]        a_tprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod  <= prod_c;
      a_den   <= den_c;
      a_chan  <= channel;
      a_cls   <= cls_c;
      a_tdef  <= soil_temp_f[16];
      a_tneg  <= tdiff[16];
      a_tprod <= tx * RECIP9;
    end
  end

  // Stage B: Celsius temperature, truncated toward zero, or TC_DEFAULT when bit 16 flags it absent.
  logic               b_valid;
  logic signed [45:0] b_prod;
  logic signed [24:0] b_den;
  logic [3:0]         b_chan;
  cls_t               b_cls;
  logic signed [24:0] b_tc;
  logic signed [24:0] tmag_c;

  assign tmag_c = $signed({1'b0, a_tprod[53:30]});

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_prod <= a_prod;
      b_den  <= a_den;
      b_chan <= a_chan;
      b_cls  <= a_cls;
      if (a_tdef) begin
        b_tc <= TC_DEFAULT;
      end else begin
        b_tc <= a_tneg ? -tmag_c : tmag_c;
      end
    end
  end

  // Resistance divider.
  logic               d1_valid;
  logic signed [39:0] d1_q;
  logic               d1_sat;
  logic [31:0]        d1_side;

  rstc_divider #(
    .NUMW(46),
    .DENW(25),
    .SW  (32)
  ) u_div_res (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (b_valid),
    .num      (b_prod),
    .den      (b_den),
    .side     ({b_chan, b_cls, b_tc}),
    .out_valid(d1_valid),
    .quo      (d1_q),
    .sat      (d1_sat),
    .out_side (d1_side)
  );

  // Stage C: partial products of the tension numerator and divisor.
  logic [41:0]        plo_c;
  logic signed [42:0] phi_c;
  logic signed [53:0] dr_c;
  logic signed [48:0] tt_c;

  always_comb begin
    plo_c = d1_q[19:0] * RES_K;
    phi_c = $signed(d1_q[39:20]) * $signed({1'b0, RES_K});
    dr_c  = d1_q * $signed({1'b0, SLOPE_K});
    tt_c  = $signed(d1_side[24:0]) * $signed({1'b0, TEMP_K});
  end

  logic               c_valid;
  logic [41:0]        c_plo;
  logic signed [42:0] c_phi;
  logic signed [53:0] c_dr;
  logic signed [48:0] c_tt;
  logic signed [39:0] c_q;
  logic               c_sat;
  logic [3:0]         c_chan;
  cls_t               c_cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_plo  <= plo_c;
      c_phi  <= phi_c;
      c_dr   <= dr_c;
      c_tt   <= tt_c;
      c_q    <= d1_q;
      c_sat  <= d1_sat;
      c_chan <= d1_side[31:28];
      c_cls  <= cls_t'(d1_side[27:25]);
    end
  end

  // Stage D: tension numerator and divisor.
  logic signed [62:0] num2_c;
  logic signed [55:0] den2_c;
  cls_t               cls_d_c;

  always_comb begin
    num2_c = NUM_K + (63'(c_phi) <<< 20) + $signed(63'(c_plo));
    den2_c = DEN_K - 56'(c_dr) - 56'(c_tt);
    cls_d_c = c_cls;
    if (c_cls == CLS_TEN && (den2_c[55] || den2_c == '0)) begin
      cls_d_c = CLS_TDIV;
    end
  end

  logic               d_valid;
  logic signed [62:0] d_num;
  logic signed [55:0] d_den;
  logic signed [39:0] d_q;
  logic               d_sat;
  logic [3:0]         d_chan;
  cls_t               d_cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_num  <= num2_c;
      d_den  <= den2_c;
      d_q    <= c_q;
      d_sat  <= c_sat;
      d_chan <= c_chan;
      d_cls  <= cls_d_c;
    end
  end

  // Tension divider.
  logic signed [39:0] d2_q;
  logic               d2_sat;
  logic [47:0]        d2_side;

  rstc_divider #(
    .NUMW(63),
    .DENW(56),
    .SW  (48)
  ) u_div_ten (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_valid),
    .num      (d_num),
    .den      (d_den),
    .side     ({d_q, d_sat, d_chan, d_cls}),
    .out_valid(d2_valid),
    .quo      (d2_q),
    .sat      (d2_sat),
    .out_side (d2_side)
  );

  // Output register.
  cls_t               f_cls;
  logic signed [39:0] f_r;
  logic               f_rsat;
  logic signed [39:0] reading_c;
  status_t            status_c;

  always_comb begin
    f_cls  = cls_t'(d2_side[2:0]);
    f_rsat = d2_side[7];
    f_r    = $signed(d2_side[47:8]);
    case (f_cls)
      CLS_ZERO: begin
        reading_c = '0;
        status_c  = STAT_OK;
      end
      CLS_DIVZ: begin
        reading_c = RD_MAX;
        status_c  = STAT_DIVZ;
      end
      CLS_RES: begin
        reading_c = f_r;
        status_c  = f_rsat ? STAT_SAT : STAT_OK;
      end
      CLS_TEN: begin
        reading_c = d2_q;
        status_c  = d2_sat ? STAT_SAT : STAT_OK;
      end
      CLS_TDIV: begin
        reading_c = RD_MAX;
        status_c  = STAT_TDIV;
      end
      default: begin
        reading_c = '0;
        status_c  = STAT_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      channel_out <= d2_side[6:3];
      reading     <= reading_c;
      status      <= status_c;
    end
  end

`ifndef SYNTHESIS
  a_divz_max : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_DIVZ |-> reading == RD_MAX)
    else $error("current divisor fault without full-scale reading");

  a_tdiv_max : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_TDIV |-> reading == RD_MAX)
    else $error("tension divisor fault without full-scale reading");

  a_bad_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_BAD |-> reading == '0)
    else $error("bad kind with nonzero reading");

  a_hold_full : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && d2_valid |=> $stable(d2_q) && d2_valid)
    else $error("tension divider moved while output was blocked");
`endif

endmodule

`default_nettype wire
